/* hw/rtl/mtsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor torque/speed controller package
// Widths of the shared serial multiplier and divider, fixed-point constants,
// operating modes and register indexes.
// ----------------------------------------------------------------------------
package mtsc_pkg;

    // Serial multiplier: magnitude A times magnitude B, one B bit per cycle.
    localparam int MUL_A_W = 50;
    localparam int MUL_B_W = 32;
    localparam int ACC_W   = MUL_A_W + MUL_B_W;

    // Restoring divider: one quotient bit per cycle.
    localparam int DIV_N_W = 53;
    localparam int DIV_D_W = 32;

    // Fraction bits of Q16.16.
    localparam int Q_FRAC = 16;

    localparam logic [31:0] TENTH_Q   = 32'd6554;
    localparam logic [31:0] HUNDRED_Q = 32'd6553600;
    localparam logic [31:0] US_PER_S  = 32'd1000000;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_CURVE = 2'd1;
    localparam logic [1:0] MODE_PI    = 2'd2;

    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_PROP_GAIN  = 3'd1;
    localparam logic [2:0] REG_INTEG_GAIN = 3'd2;
    localparam logic [2:0] REG_TORQUE_LIM = 3'd3;
    localparam logic [2:0] REG_WINDIN_MAX = 3'd4;
    localparam logic [2:0] REG_LIFTUP_MAX = 3'd5;
    localparam logic [2:0] REG_TRQ_PER_SP = 3'd6;

endpackage

/* hw/rtl/motor_torque_speed_controller_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor torque/speed controller
// One tick in, one signed Q16.16 torque command out: off, speed-limited
// torque curve, or PI speed control with anti-windup.
// ----------------------------------------------------------------------------
// The block handles one request at a time. Each tick is latched, then a small
// sequencer drives one shared serial multiplier (one multiplier bit per cycle)
// and one restoring divider (one quotient bit per cycle) through the steps of
// the selected mode. Mode off (and the unused fourth code) goes straight to a
// zero result. The torque curve takes two divisions and at most one
// multiplication, or neither when the torque per speed is zero. PI control
// takes one multiplication, one division and two further multiplications, or
// only the two further multiplications while the integral is frozen. A
// finished result sits in an output register, so the next request is accepted
// while the previous command still waits to be taken. Configuration registers
// may be written at any time the block is idle; the configuration channel is
// always ready. Writing the mode register with a new value, or with zero,
// clears the integral and the remembered previous torque.

module motor_torque_speed_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Tick requests
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_measured_speed,
    input  logic [31:0] i_speed_ref,
    input  logic [31:0] i_torque_ref,
    input  logic [19:0] i_interval_us,
    // Torque commands
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_torque_command,
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_POST,
        S_OUT
    } t_state;

    // Step that the sequencer is on when it enters S_POST.
    typedef enum logic [2:0] {
        PH_START,
        PH_LIMW,
        PH_LIML,
        PH_CURVE,
        PH_INC,
        PH_INCDIV,
        PH_PTERM,
        PH_ITERM
    } t_phase;

    // Saturate a wide signed value into 32 bits.
    function automatic logic signed [31:0] f_sat32(input logic signed [67:0] v);
        logic signed [67:0] hi;
        logic signed [67:0] lo;
        hi = $signed({36'd0, 32'h7fff_ffff});
        lo = $signed({{36{1'b1}}, 32'h8000_0000});
        if (v > hi) begin
            f_sat32 = $signed(32'h7fff_ffff);
        end else if (v < lo) begin
            f_sat32 = $signed(32'h8000_0000);
        end else begin
            f_sat32 = v[31:0];
        end
    endfunction

    // Configuration registers
    logic [1:0]         r_mode, n_mode;
    logic signed [31:0] r_prop_gain, n_prop_gain;
    logic signed [31:0] r_integ_gain, n_integ_gain;
    logic [30:0]        r_torque_limit, n_torque_limit;
    logic signed [31:0] r_windin, n_windin;
    logic signed [31:0] r_liftup, n_liftup;
    logic signed [31:0] r_tps, n_tps;

    // Controller state
    logic signed [31:0] r_integral, n_integral;
    logic signed [31:0] r_last_torque, n_last_torque;

    // Sequencer
    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [5:0]         r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;

    // Latched tick and work registers
    logic signed [31:0] r_s, n_s;
    logic signed [31:0] r_sref, n_sref;
    logic signed [31:0] r_tref, n_tref;
    logic [19:0]        r_interval, n_interval;
    logic [mtsc_pkg::MUL_A_W-1:0] r_mul_a, n_mul_a;
    logic [mtsc_pkg::MUL_B_W-1:0] r_mul_b, n_mul_b;
    logic [mtsc_pkg::ACC_W-1:0]   r_acc, n_acc;
    logic [mtsc_pkg::DIV_N_W-1:0] r_quo, n_quo;
    logic [mtsc_pkg::DIV_D_W-1:0] r_rem, n_rem;
    logic [mtsc_pkg::DIV_D_W-1:0] r_dvs, n_dvs;
    logic               r_neg, n_neg;
    logic               r_add_tref, n_add_tref;
    logic signed [49:0] r_limw, n_limw;
    logic signed [48:0] r_pterm, n_pterm;
    logic signed [31:0] r_res, n_res;
    logic [31:0]        r_torque_command, n_torque_command;

    // Derived values
    logic signed [31:0] w_eff, l_eff;
    logic signed [32:0] err;
    logic [32:0]        err_mag;
    logic [30:0]        tref_c;
    logic [31:0]        d_mag, pg_mag, ig_mag, integ_mag;
    logic [32:0]        last_mag;
    logic               windup_ok;
    logic signed [32:0] lim_m_tref;
    logic [31:0]        lim_m_tref_mag;
    logic signed [49:0] quo_ext, quo_sv;
    logic signed [66:0] prod_ext, prod_sv;
    logic signed [49:0] s_ext50, liml, lim50;
    logic signed [33:0] neg_l_m_s;
    logic signed [49:0] pi_sum;
    logic [33:0]        div_diff;
    logic               div_ge;
    logic               w_in_accept, w_out_free;

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_torque_command = r_torque_command;
    assign o_cfg_ready      = 1'b1;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Nonpositive speed thresholds read as 100.0.
    assign w_eff = (r_windin > 32'sd0) ? r_windin : $signed(mtsc_pkg::HUNDRED_Q);
    assign l_eff = (r_liftup > 32'sd0) ? r_liftup : $signed(mtsc_pkg::HUNDRED_Q);

    assign err     = $signed({r_sref[31], r_sref}) - $signed({r_s[31], r_s});
    assign err_mag = err[32] ? 33'(-err) : 33'(err);
    assign tref_c  = r_tref[31] ? 31'd0 : r_tref[30:0];

    assign d_mag     = r_tps[31] ? 32'(-r_tps) : 32'(r_tps);
    assign pg_mag    = r_prop_gain[31] ? 32'(-r_prop_gain) : 32'(r_prop_gain);
    assign ig_mag    = r_integ_gain[31] ? 32'(-r_integ_gain) : 32'(r_integ_gain);
    assign integ_mag = r_integral[31] ? 32'(-r_integral) : 32'(r_integral);
    assign last_mag  = r_last_torque[31] ? 33'(-$signed({1'b1, r_last_torque}))
                                         : {1'b0, r_last_torque};

    // The integral only moves while the previous command is clear of the limit.
    assign windup_ok = $signed({1'b0, last_mag})
                     < ($signed({3'd0, r_torque_limit}) - $signed({2'd0, mtsc_pkg::TENTH_Q}));

    assign lim_m_tref     = $signed({2'd0, r_torque_limit}) - $signed({2'd0, tref_c});
    assign lim_m_tref_mag = lim_m_tref[32] ? 32'(-lim_m_tref) : lim_m_tref[31:0];

    assign quo_ext  = $signed({1'b0, r_quo[48:0]});
    assign quo_sv   = r_neg ? -quo_ext : quo_ext;
    assign prod_ext = $signed({1'b0, r_acc[mtsc_pkg::ACC_W-1:mtsc_pkg::Q_FRAC]});
    assign prod_sv  = r_neg ? -prod_ext : prod_ext;

    assign s_ext50   = $signed({{18{r_s[31]}}, r_s});
    assign liml      = $signed({{18{l_eff[31]}}, l_eff}) + quo_sv;
    assign lim50     = $signed({19'd0, r_torque_limit});
    assign neg_l_m_s = -$signed({{2{l_eff[31]}}, l_eff}) - $signed({{2{r_s[31]}}, r_s});
    assign pi_sum    = $signed({r_pterm[48], r_pterm}) + prod_sv[49:0];

    // One restoring division step.
    assign div_diff = {1'b0, r_rem, r_quo[mtsc_pkg::DIV_N_W-1]} - {2'd0, r_dvs};
    assign div_ge   = !div_diff[33];

    always_comb begin
        n_mode           = r_mode;
        n_prop_gain      = r_prop_gain;
        n_integ_gain     = r_integ_gain;
        n_torque_limit   = r_torque_limit;
        n_windin         = r_windin;
        n_liftup         = r_liftup;
        n_tps            = r_tps;
        n_integral       = r_integral;
        n_last_torque    = r_last_torque;
        n_state          = r_state;
        n_phase          = r_phase;
        n_cnt            = r_cnt;
        n_out_valid      = r_out_valid;
        n_s              = r_s;
        n_sref           = r_sref;
        n_tref           = r_tref;
        n_interval       = r_interval;
        n_mul_a          = r_mul_a;
        n_mul_b          = r_mul_b;
        n_acc            = r_acc;
        n_quo            = r_quo;
        n_rem            = r_rem;
        n_dvs            = r_dvs;
        n_neg            = r_neg;
        n_add_tref       = r_add_tref;
        n_limw           = r_limw;
        n_pterm          = r_pterm;
        n_res            = r_res;
        n_torque_command = r_torque_command;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mtsc_pkg::REG_MODE: begin
                    if (i_cfg_data[1:0] != r_mode || i_cfg_data[1:0] == mtsc_pkg::MODE_OFF) begin
                        n_integral    = '0;
                        n_last_torque = '0;
                    end
                    n_mode = i_cfg_data[1:0];
                end
                mtsc_pkg::REG_PROP_GAIN:  n_prop_gain    = i_cfg_data;
                mtsc_pkg::REG_INTEG_GAIN: n_integ_gain   = i_cfg_data;
                mtsc_pkg::REG_TORQUE_LIM: n_torque_limit = i_cfg_data[30:0];
                mtsc_pkg::REG_WINDIN_MAX: n_windin       = i_cfg_data;
                mtsc_pkg::REG_LIFTUP_MAX: n_liftup       = i_cfg_data;
                mtsc_pkg::REG_TRQ_PER_SP: n_tps          = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_s        = i_measured_speed;
                    n_sref     = i_speed_ref;
                    n_tref     = i_torque_ref;
                    n_interval = i_interval_us;
                    n_phase    = PH_START;
                    n_state    = S_POST;
                end
            end

            S_MUL: begin
                n_acc   = {r_acc[mtsc_pkg::ACC_W-2:0], 1'b0}
                        + (r_mul_b[mtsc_pkg::MUL_B_W-1]
                           ? {{mtsc_pkg::MUL_B_W{1'b0}}, r_mul_a} : '0);
                n_mul_b = {r_mul_b[mtsc_pkg::MUL_B_W-2:0], 1'b0};
                n_cnt   = r_cnt + 6'd1;
                if (r_cnt == 6'(mtsc_pkg::MUL_B_W - 1)) begin
                    n_state = S_POST;
                end
            end

            S_DIV: begin
                n_rem = div_ge ? div_diff[31:0] : {r_rem[30:0], r_quo[mtsc_pkg::DIV_N_W-1]};
                n_quo = {r_quo[mtsc_pkg::DIV_N_W-2:0], div_ge};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(mtsc_pkg::DIV_N_W - 1)) begin
                    n_state = S_POST;
                end
            end

            S_POST: begin
                n_cnt = '0;
                unique case (r_phase)
                    PH_START: begin
                        if (r_mode == mtsc_pkg::MODE_CURVE) begin
                            if (r_tps == 32'sd0) begin
                                n_res   = '0;
                                n_state = S_OUT;
                            end else begin
                                // Wind-in breakpoint: W + tref / d.
                                n_quo   = {6'd0, tref_c, 16'd0};
                                n_rem   = '0;
                                n_dvs   = d_mag;
                                n_neg   = r_tps[31];
                                n_phase = PH_LIMW;
                                n_state = S_DIV;
                            end
                        end else if (r_mode == mtsc_pkg::MODE_PI) begin
                            if (windup_ok) begin
                                n_mul_a = {17'd0, err_mag};
                                n_mul_b = {12'd0, r_interval};
                                n_acc   = '0;
                                n_neg   = err[32];
                                n_phase = PH_INC;
                            end else begin
                                n_mul_a = {17'd0, err_mag};
                                n_mul_b = pg_mag;
                                n_acc   = '0;
                                n_neg   = err[32] ^ r_prop_gain[31];
                                n_phase = PH_PTERM;
                            end
                            n_state = S_MUL;
                        end else begin
                            n_res   = '0;
                            n_state = S_OUT;
                        end
                    end

                    PH_LIMW: begin
                        n_limw  = $signed({{18{w_eff[31]}}, w_eff}) + quo_sv;
                        // Lift-up breakpoint: L + (limit - tref) / d.
                        n_quo   = {5'd0, lim_m_tref_mag, 16'd0};
                        n_rem   = '0;
                        n_dvs   = d_mag;
                        n_neg   = lim_m_tref[32] ^ r_tps[31];
                        n_phase = PH_LIML;
                        n_state = S_DIV;
                    end

                    PH_LIML: begin
                        n_acc = '0;
                        n_neg = r_tps[31];
                        if (s_ext50 > r_limw) begin
                            n_res   = '0;
                            n_state = S_OUT;
                        end else if (r_s > w_eff) begin
                            n_mul_a    = 50'(r_limw - s_ext50);
                            n_mul_b    = d_mag;
                            n_add_tref = 1'b0;
                            n_phase    = PH_CURVE;
                            n_state    = S_MUL;
                        end else if ($signed({r_s[31], r_s}) > -$signed({l_eff[31], l_eff})) begin
                            n_res   = $signed({1'b0, tref_c});
                            n_state = S_OUT;
                        end else if (s_ext50 > -liml) begin
                            n_mul_a    = {16'd0, neg_l_m_s};
                            n_mul_b    = d_mag;
                            n_add_tref = 1'b1;
                            n_phase    = PH_CURVE;
                            n_state    = S_MUL;
                        end else begin
                            n_res   = $signed({1'b0, r_torque_limit});
                            n_state = S_OUT;
                        end
                    end

                    PH_CURVE: begin
                        n_res   = f_sat32($signed({prod_sv[66], prod_sv})
                                          + (r_add_tref ? $signed({37'd0, tref_c})
                                                        : 68'sd0));
                        n_state = S_OUT;
                    end

                    PH_INC: begin
                        n_quo   = r_acc[mtsc_pkg::DIV_N_W-1:0];
                        n_rem   = '0;
                        n_dvs   = mtsc_pkg::US_PER_S;
                        n_phase = PH_INCDIV;
                        n_state = S_DIV;
                    end

                    PH_INCDIV: begin
                        n_integral = f_sat32($signed({{36{r_integral[31]}}, r_integral})
                                             + $signed({{18{quo_sv[49]}}, quo_sv}));
                        n_mul_a    = {17'd0, err_mag};
                        n_mul_b    = pg_mag;
                        n_acc      = '0;
                        n_neg      = err[32] ^ r_prop_gain[31];
                        n_phase    = PH_PTERM;
                        n_state    = S_MUL;
                    end

                    PH_PTERM: begin
                        n_pterm = prod_sv[48:0];
                        n_mul_a = {18'd0, integ_mag};
                        n_mul_b = ig_mag;
                        n_acc   = '0;
                        n_neg   = r_integral[31] ^ r_integ_gain[31];
                        n_phase = PH_ITERM;
                        n_state = S_MUL;
                    end

                    PH_ITERM: begin
                        if (pi_sum > lim50) begin
                            n_res = $signed({1'b0, r_torque_limit});
                        end else if (pi_sum < -lim50) begin
                            n_res = -$signed({1'b0, r_torque_limit});
                        end else begin
                            n_res = pi_sum[31:0];
                        end
                        n_state = S_OUT;
                    end

                    default: n_state = S_IDLE;
                endcase
            end

            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_torque_command = r_res;
                    n_last_torque    = r_res;
                    n_state          = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_mode         <= mtsc_pkg::MODE_OFF;
            r_prop_gain    <= '0;
            r_integ_gain   <= '0;
            r_torque_limit <= '0;
            r_windin       <= '0;
            r_liftup       <= '0;
            r_tps          <= 32'sd65536;
            r_integral     <= '0;
            r_last_torque  <= '0;
        end else begin
            r_state        <= n_state;
            r_out_valid    <= n_out_valid;
            r_mode         <= n_mode;
            r_prop_gain    <= n_prop_gain;
            r_integ_gain   <= n_integ_gain;
            r_torque_limit <= n_torque_limit;
            r_windin       <= n_windin;
            r_liftup       <= n_liftup;
            r_tps          <= n_tps;
            r_integral     <= n_integral;
            r_last_torque  <= n_last_torque;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase          <= n_phase;
        r_cnt            <= n_cnt;
        r_s              <= n_s;
        r_sref           <= n_sref;
        r_tref           <= n_tref;
        r_interval       <= n_interval;
        r_mul_a          <= n_mul_a;
        r_mul_b          <= n_mul_b;
        r_acc            <= n_acc;
        r_quo            <= n_quo;
        r_rem            <= n_rem;
        r_dvs            <= n_dvs;
        r_neg            <= n_neg;
        r_add_tref       <= n_add_tref;
        r_limw           <= n_limw;
        r_pterm          <= n_pterm;
        r_res            <= n_res;
        r_torque_command <= n_torque_command;
    end

endmodule
